@@ design/hssds_pkg.sv @@
package hssds_pkg;

    localparam int SAMPLES_PER_MEAN = 8;
    localparam int ADC_FULL_SCALE   = 4096;
    localparam int SCALE_NUM        = 10000;
    localparam int SCALED_MAX       = 10000;

    localparam int ADC_W     = 12;
    localparam int SCALED_W  = 14;
    localparam int COUNT_W   = 7;
    localparam int SUM_W     = 18;
    localparam int PROD_W    = ADC_W + SCALED_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 14;

    typedef enum logic [1:0] {
        REQ_TICK         = 2'd0,
        REQ_SWITCH       = 2'd1,
        REQ_READ_CURRENT = 2'd2,
        REQ_READ_DIAG    = 2'd3
    } t_req_type;

    typedef enum logic {
        PHASE_SELECT = 1'b0,
        PHASE_SAMPLE = 1'b1
    } t_scan_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_GROUND = 3'd0,
        CFG_OC_CH0       = 3'd1,
        CFG_OC_CH1       = 3'd2,
        CFG_OL_THR_CH1   = 3'd3,
        CFG_OL_MASK_CH1  = 3'd4
    } t_cfg_index;

    localparam logic [ADC_W-1:0]    RST_SHORT_GROUND = 12'd4000;
    localparam logic [ADC_W-1:0]    RST_OC_CH0       = 12'd1000;
    localparam logic [ADC_W-1:0]    RST_OC_CH1       = 12'd2500;
    localparam logic [SCALED_W-1:0] RST_OL_THR_CH1   = 14'd30;

endpackage

@@ design/high_side_switch_diagnostic_scanner_core.sv @@
// two-channel high-side switch monitor
// input channel: i_in_valid / o_in_stall carry one request word (tick with adc
// sample, switch command, current read or diagnosis read); output channel:
// o_out_valid / i_out_stall carry one result word per request
// a word is taken on a rising edge with valid high and stall low
// path: an accepted word sits in the input register, then loads the result
// register once that is empty or draining, and o_out_valid marks the result;
// throughput one word per cycle while i_out_stall stays low, set by the
// single pass through the mean multiply-and-shift between those two
// registers
// enable and sense-select outputs show the switch state after the word held
// in the result register
// configuration: i_cfg_we writes register i_cfg_index with i_cfg_data; write
// only while no word is in flight
// reset (synchronous, active low) clears the pipeline, switches all off, mean
// valid and fresh marks, scan state, and loads the default thresholds
// when the receiver stalls, the result holds and the input register fills;
// o_in_stall rises once both registers are occupied, so nothing is lost
module high_side_switch_diagnostic_scanner_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [1:0]                            i_req_type,
    input  logic [1:0]                            i_channel,
    input  logic                                  i_switch_on,
    input  logic [hssds_pkg::ADC_W-1:0]           i_adc_sample,
    input  logic                                  i_adc_valid,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_status,
    output logic [hssds_pkg::SCALED_W-1:0]        o_current_scaled,
    output logic                                  o_short_to_ground,
    output logic                                  o_over_current,
    output logic                                  o_open_load,
    output logic                                  o_enable_ch0,
    output logic                                  o_enable_ch1,
    output logic                                  o_sense_select,
    output logic                                  o_average_done,
    input  logic                                  i_cfg_we,
    input  logic [hssds_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hssds_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // configuration
    logic [hssds_pkg::ADC_W-1:0]    r_short_thr;
    logic [hssds_pkg::ADC_W-1:0]    r_oc_thr_ch0;
    logic [hssds_pkg::ADC_W-1:0]    r_oc_thr_ch1;
    logic [hssds_pkg::SCALED_W-1:0] r_ol_thr_ch1;
    logic                           r_ol_mask_ch1;

    // input register
    logic                           r_in_valid;
    hssds_pkg::t_req_type           r_req_type;
    logic [1:0]                     r_channel;
    logic                           r_switch_on;
    logic [hssds_pkg::ADC_W-1:0]    r_adc_sample;
    logic                           r_adc_valid;

    // scan state
    hssds_pkg::t_scan_phase         r_scan_phase, n_scan_phase;
    logic                           r_scan_channel, n_scan_channel;
    logic [1:0]                     r_channel_on, n_channel_on;
    logic [hssds_pkg::ADC_W-1:0]    r_mean_value [2];
    logic [1:0]                     r_mean_valid, n_mean_valid;
    logic [1:0]                     r_mean_fresh, n_mean_fresh;
    logic [hssds_pkg::COUNT_W-1:0]  r_sample_count, n_sample_count;
    logic [hssds_pkg::SUM_W-1:0]    r_sample_sum, n_sample_sum;
    logic                           r_mux_select, n_mux_select;

    // result register
    logic                           r_out_valid;
    logic                           r_status, n_status;
    logic [hssds_pkg::SCALED_W-1:0] r_current, n_current;
    logic                           r_sg, n_sg;
    logic                           r_oc, n_oc;
    logic                           r_ol, n_ol;
    logic                           r_done, n_done;

    logic                           w_out_ready;
    logic                           w_fire;
    logic                           w_bad;
    logic                           w_c;
    logic [hssds_pkg::SUM_W-1:0]    w_sum_add;
    logic [hssds_pkg::COUNT_W-1:0]  w_count_inc;
    logic                           w_mean_wr;
    logic [hssds_pkg::ADC_W-1:0]    w_mean_new;
    logic [hssds_pkg::ADC_W-1:0]    w_mean;
    logic [hssds_pkg::PROD_W-1:0]   w_prod;
    logic [hssds_pkg::PROD_W-1:0]   w_scaled;
    logic [hssds_pkg::ADC_W-1:0]    w_oc_thr;

    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_fire      = r_in_valid && w_out_ready;
    assign o_in_stall  = r_in_valid && !w_out_ready;

    assign w_bad = r_channel[1];
    assign w_c   = r_channel[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_thr   <= hssds_pkg::RST_SHORT_GROUND;
            r_oc_thr_ch0  <= hssds_pkg::RST_OC_CH0;
            r_oc_thr_ch1  <= hssds_pkg::RST_OC_CH1;
            r_ol_thr_ch1  <= hssds_pkg::RST_OL_THR_CH1;
            r_ol_mask_ch1 <= 1'b0;
        end else if (i_cfg_we) begin
            case (hssds_pkg::t_cfg_index'(i_cfg_index))
                hssds_pkg::CFG_SHORT_GROUND: r_short_thr   <= i_cfg_data[hssds_pkg::ADC_W-1:0];
                hssds_pkg::CFG_OC_CH0:       r_oc_thr_ch0  <= i_cfg_data[hssds_pkg::ADC_W-1:0];
                hssds_pkg::CFG_OC_CH1:       r_oc_thr_ch1  <= i_cfg_data[hssds_pkg::ADC_W-1:0];
                hssds_pkg::CFG_OL_THR_CH1:   r_ol_thr_ch1  <= i_cfg_data;
                hssds_pkg::CFG_OL_MASK_CH1:  r_ol_mask_ch1 <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register loads whenever it is empty or drains this cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_req_type   <= hssds_pkg::t_req_type'(i_req_type);
            r_channel    <= i_channel;
            r_switch_on  <= i_switch_on;
            r_adc_sample <= i_adc_sample;
            r_adc_valid  <= i_adc_valid;
        end
    end

    assign w_sum_add   = r_sample_sum + hssds_pkg::SUM_W'(r_adc_sample);
    assign w_count_inc = r_sample_count + 1'b1;
    assign w_mean_new  = hssds_pkg::ADC_W'(w_sum_add / hssds_pkg::SUM_W'(hssds_pkg::SAMPLES_PER_MEAN));

    // next scan state
    always_comb begin
        n_scan_phase   = r_scan_phase;
        n_scan_channel = r_scan_channel;
        n_channel_on   = r_channel_on;
        n_mean_valid   = r_mean_valid;
        n_mean_fresh   = r_mean_fresh;
        n_sample_count = r_sample_count;
        n_sample_sum   = r_sample_sum;
        n_mux_select   = r_mux_select;
        w_mean_wr      = 1'b0;
        case (r_req_type)
            hssds_pkg::REQ_TICK: begin
                case (r_scan_phase)
                    hssds_pkg::PHASE_SELECT: begin
                        if (r_channel_on[r_scan_channel]) begin
                            n_mux_select = r_scan_channel;
                            n_scan_phase = hssds_pkg::PHASE_SAMPLE;
                        end else begin
                            n_scan_channel = !r_scan_channel;
                        end
                    end
                    hssds_pkg::PHASE_SAMPLE: begin
                        if (r_adc_valid) begin
                            n_sample_sum   = w_sum_add;
                            n_sample_count = w_count_inc;
                            if (w_count_inc >= hssds_pkg::COUNT_W'(hssds_pkg::SAMPLES_PER_MEAN)) begin
                                w_mean_wr                    = 1'b1;
                                n_mean_valid[r_scan_channel] = 1'b1;
                                n_mean_fresh[r_scan_channel] = 1'b1;
                                n_sample_sum                 = '0;
                                n_sample_count               = '0;
                                n_scan_channel               = !r_scan_channel;
                                n_scan_phase                 = hssds_pkg::PHASE_SELECT;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            hssds_pkg::REQ_SWITCH: begin
                if (!w_bad) n_channel_on[w_c] = r_switch_on;
            end
            hssds_pkg::REQ_READ_DIAG: begin
                if (!w_bad) n_mean_fresh[w_c] = 1'b0;
            end
            default: ;
        endcase
    end

    assign w_mean   = r_mean_value[w_c];
    assign w_prod   = hssds_pkg::PROD_W'(w_mean) * hssds_pkg::PROD_W'(hssds_pkg::SCALE_NUM);
    assign w_scaled = w_prod / hssds_pkg::PROD_W'(hssds_pkg::ADC_FULL_SCALE);
    assign w_oc_thr = w_c ? r_oc_thr_ch1 : r_oc_thr_ch0;

    // result word
    always_comb begin
        n_status  = 1'b0;
        n_current = '0;
        n_sg      = 1'b0;
        n_oc      = 1'b0;
        n_ol      = 1'b0;
        n_done    = w_mean_wr;
        case (r_req_type)
            hssds_pkg::REQ_SWITCH: begin
                n_status = w_bad;
            end
            hssds_pkg::REQ_READ_CURRENT: begin
                if (w_bad || !r_mean_valid[w_c]) begin
                    n_status = 1'b1;
                end else if (w_scaled > hssds_pkg::PROD_W'(hssds_pkg::SCALED_MAX)) begin
                    n_current = hssds_pkg::SCALED_W'(hssds_pkg::SCALED_MAX);
                end else begin
                    n_current = w_scaled[hssds_pkg::SCALED_W-1:0];
                end
            end
            hssds_pkg::REQ_READ_DIAG: begin
                if (w_bad) begin
                    n_status = 1'b1;
                end else if (r_mean_fresh[w_c]) begin
                    if (w_mean > r_short_thr) begin
                        n_sg = 1'b1;
                    end else if (w_mean > w_oc_thr) begin
                        n_oc = 1'b1;
                    end else if (!w_c) begin
                        n_ol = (w_scaled == '0);
                    end else if (!r_ol_mask_ch1) begin
                        n_ol = (w_scaled < hssds_pkg::PROD_W'(r_ol_thr_ch1));
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_phase   <= hssds_pkg::PHASE_SELECT;
            r_scan_channel <= 1'b0;
            r_channel_on   <= '0;
            r_mean_valid   <= '0;
            r_mean_fresh   <= '0;
            r_sample_count <= '0;
            r_sample_sum   <= '0;
            r_mux_select   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_fire) begin
                r_scan_phase   <= n_scan_phase;
                r_scan_channel <= n_scan_channel;
                r_channel_on   <= n_channel_on;
                r_mean_valid   <= n_mean_valid;
                r_mean_fresh   <= n_mean_fresh;
                r_sample_count <= n_sample_count;
                r_sample_sum   <= n_sample_sum;
                r_mux_select   <= n_mux_select;
            end
            if (w_out_ready) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            if (w_mean_wr) r_mean_value[r_scan_channel] <= w_mean_new;
            r_status  <= n_status;
            r_current <= n_current;
            r_sg      <= n_sg;
            r_oc      <= n_oc;
            r_ol      <= n_ol;
            r_done    <= n_done;
        end
    end

    // switch state only moves when a result word is loaded
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_current_scaled  = r_current;
    assign o_short_to_ground = r_sg;
    assign o_over_current    = r_oc;
    assign o_open_load       = r_ol;
    assign o_enable_ch0      = r_channel_on[0];
    assign o_enable_ch1      = r_channel_on[1];
    assign o_sense_select    = r_mux_select;
    assign o_average_done    = r_done;

endmodule
